FILE: rtl/core/lps_pkg.sv
package lps_pkg;

  localparam int LED_COUNT  = 8;
  localparam int POS_W      = (LED_COUNT > 2) ? $clog2(LED_COUNT) : 1;
  localparam int LED_OUT_W  = 8;
  localparam int CHUNK_W    = 10;
  localparam int DB_W       = 10;
  localparam int TICK_W     = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int DIV_CNT_W  = $clog2(TICK_W + 1);

  localparam logic [CFG_IDX_W-1:0] REG_CHECK_CHUNK = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLANK       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALT_FRAME   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCAN_FRAME  = 3'd4;

  localparam logic [CHUNK_W-1:0] RST_CHECK_CHUNK = 10'd50;
  localparam logic [DB_W-1:0]    RST_DEBOUNCE    = 10'd30;
  localparam logic [TICK_W-1:0]  RST_BLANK       = 12'd200;
  localparam logic [TICK_W-1:0]  RST_ALT_FRAME   = 12'd400;
  localparam logic [TICK_W-1:0]  RST_SCAN_FRAME  = 12'd120;

  localparam logic [2:0] PH_SHOW    = 3'd0;
  localparam logic [2:0] PH_CONFIRM = 3'd1;
  localparam logic [2:0] PH_RELEASE = 3'd2;
  localparam logic [2:0] PH_REL_DB  = 3'd3;
  localparam logic [2:0] PH_BLANK   = 3'd4;

  typedef struct packed {
    logic                 blanking;
    logic                 pattern_mode;
    logic [LED_OUT_W-1:0] led_pattern;
  } result_t;

endpackage

FILE: rtl/core/led_pattern_sequencer_top.sv
// Channel   | Dir | Item contents (tdata / tuser)             | Accept
// s_axis    | in  | tdata[0] button_level                     | tvalid & tready
// m_axis    | out | tdata[7:0] led_pattern, tuser mode/blank  | tvalid & tready
// cfg       | in  | cfg_index_i register index, cfg_data_i    | cfg_valid_i & cfg_ready_o
//
// One tick item per cycle unless the input is held off; each result is registered for output.
// After reset and after every register write, the input is held off while
// a shift-subtract remainder unit (one bit per cycle) computes the last sample tick of
// each frame length.
// A stalled output holds its item; input is taken while the output drains the same cycle.
// Configuration writes are always taken.
module led_pattern_sequencer_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [7:0]                      s_axis_tdata_i,  // [0] button_level
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [7:0]                      m_axis_tdata_o,  // [7:0] led_pattern
  output logic [1:0]                      m_axis_tuser_o,  // [0] pattern_mode, [1] blanking
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [lps_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [lps_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import lps_pkg::*;

  logic [CHUNK_W-1:0] chunk_cfg_q;
  logic [DB_W-1:0]    db_cfg_q;
  logic [TICK_W-1:0]  blank_cfg_q, alt_cfg_q, scan_cfg_q;

  logic               mode_q, mode_d, odd_q, odd_d, down_q, down_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [2:0]         phase_q, phase_d;
  logic [TICK_W-1:0]  chunk_q, chunk_d, frame_q, frame_d, wait_q, wait_d;

  logic               start_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic [TICK_W-1:0]  na_q, ns_q;
  logic [CHUNK_W-1:0] ra_q, rs_q;
  logic               busy;

  logic               out_valid_q;
  result_t            out_q, res;

  logic               cfg_we, in_acc, lvl;
  logic [CHUNK_W-1:0] chunk_eff;
  logic [TICK_W-1:0]  alt_eff, scan_eff, flen, full;
  logic [CHUNK_W:0]   ta, ts;
  logic [TICK_W:0]    wait_inc, frame_inc, chunk_inc;
  logic               show_eff, toggle_f, finish_f, endframe_f;
  logic               ef_odd, ef_down;
  logic [POS_W-1:0]   ef_pos;
  logic [LED_OUT_W-1:0] pat;

  localparam logic [POS_W-1:0] POS_TOP = POS_W'(LED_COUNT - 1);

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;
  assign busy        = start_q | (div_cnt_q != '0);
  assign s_axis_tready_o = ~busy & (~out_valid_q | m_axis_tready_i);
  assign in_acc      = s_axis_tvalid_i & s_axis_tready_o;
  assign lvl         = s_axis_tdata_i[0];

  assign chunk_eff = (chunk_cfg_q == '0) ? CHUNK_W'(1) : chunk_cfg_q;
  assign alt_eff   = (alt_cfg_q == '0) ? TICK_W'(1) : alt_cfg_q;
  assign scan_eff  = (scan_cfg_q == '0) ? TICK_W'(1) : scan_cfg_q;
  assign flen      = mode_q ? scan_eff : alt_eff;
  assign full      = mode_q ? (scan_eff - TICK_W'(rs_q)) : (alt_eff - TICK_W'(ra_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_cfg_q <= RST_CHECK_CHUNK;
      db_cfg_q    <= RST_DEBOUNCE;
      blank_cfg_q <= RST_BLANK;
      alt_cfg_q   <= RST_ALT_FRAME;
      scan_cfg_q  <= RST_SCAN_FRAME;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        REG_CHECK_CHUNK: chunk_cfg_q <= cfg_data_i[CHUNK_W-1:0];
        REG_DEBOUNCE:    db_cfg_q    <= cfg_data_i[DB_W-1:0];
        REG_BLANK:       blank_cfg_q <= cfg_data_i[TICK_W-1:0];
        REG_ALT_FRAME:   alt_cfg_q   <= cfg_data_i[TICK_W-1:0];
        REG_SCAN_FRAME:  scan_cfg_q  <= cfg_data_i[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // frame length mod chunk, both modes, one bit per cycle
  assign ta = {ra_q, na_q[TICK_W-1]};
  assign ts = {rs_q, ns_q[TICK_W-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q   <= 1'b1;
      div_cnt_q <= '0;
      ra_q      <= '0;
      rs_q      <= '0;
    end else if (cfg_we) begin
      start_q   <= 1'b1;
      div_cnt_q <= '0;
    end else if (start_q) begin
      start_q   <= 1'b0;
      div_cnt_q <= DIV_CNT_W'(TICK_W);
      ra_q      <= '0;
      rs_q      <= '0;
    end else if (div_cnt_q != '0) begin
      div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
      ra_q <= (ta >= {1'b0, chunk_eff}) ? CHUNK_W'(ta - {1'b0, chunk_eff}) : CHUNK_W'(ta);
      rs_q <= (ts >= {1'b0, chunk_eff}) ? CHUNK_W'(ts - {1'b0, chunk_eff}) : CHUNK_W'(ts);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_q) begin
      na_q <= alt_eff;
      ns_q <= scan_eff;
    end else begin
      na_q <= {na_q[TICK_W-2:0], 1'b0};
      ns_q <= {ns_q[TICK_W-2:0], 1'b0};
    end
  end

  // pattern and scanner step
  always_comb begin
    pat = '0;
    for (int i = 0; i < LED_OUT_W; i++) begin
      if (i < LED_COUNT) begin
        if (mode_q) begin
          pat[i] = (pos_q == POS_W'(i));
        end else begin
          pat[i] = (((i % 2) != 0) == odd_q);
        end
      end
    end
  end

  always_comb begin
    ef_pos = pos_q;
    if (down_q) begin
      if (pos_q != '0) ef_pos = pos_q - POS_W'(1);
    end else if (pos_q < POS_TOP) begin
      ef_pos = pos_q + POS_W'(1);
    end
    ef_down = down_q;
    if (ef_pos >= POS_TOP) ef_down = 1'b1;
    if (ef_pos == '0) ef_down = 1'b0;
    ef_odd = ~odd_q;
  end

  assign show_eff         = (phase_q > PH_BLANK) || (phase_q == PH_SHOW);
  assign res.led_pattern  = (phase_q == PH_BLANK) ? '0 : pat;
  assign res.pattern_mode = mode_q;
  assign res.blanking     = ~show_eff;

  assign wait_inc  = {1'b0, wait_q} + (TICK_W+1)'(1);
  assign frame_inc = {1'b0, frame_q} + (TICK_W+1)'(1);
  assign chunk_inc = {1'b0, chunk_q} + (TICK_W+1)'(1);

  always_comb begin
    mode_d = mode_q;
    odd_d = odd_q;
    pos_d = pos_q;
    down_d = down_q;
    phase_d = phase_q;
    chunk_d = chunk_q;
    frame_d = frame_q;
    wait_d = wait_q;
    toggle_f = 1'b0;
    finish_f = 1'b0;
    endframe_f = 1'b0;
    unique case (phase_q)
      PH_CONFIRM: begin
        wait_d = wait_inc[TICK_W-1:0];
        if (wait_inc >= (TICK_W+1)'(db_cfg_q)) begin
          if (!lvl) begin
            phase_d = PH_RELEASE;
          end else begin
            phase_d = PH_SHOW;
            endframe_f = (frame_q >= flen);
          end
        end
      end
      PH_RELEASE: begin
        if (lvl) begin
          if (db_cfg_q == '0) begin
            toggle_f = 1'b1;
          end else begin
            phase_d = PH_REL_DB;
            wait_d  = '0;
          end
        end
      end
      PH_REL_DB: begin
        wait_d = wait_inc[TICK_W-1:0];
        toggle_f = (wait_inc >= (TICK_W+1)'(db_cfg_q));
      end
      PH_BLANK: begin
        wait_d = wait_inc[TICK_W-1:0];
        finish_f = (wait_inc >= {1'b0, blank_cfg_q});
      end
      default: begin
        phase_d = PH_SHOW;
        chunk_d = chunk_inc[TICK_W-1:0];
        frame_d = frame_inc[TICK_W-1:0];
        if (chunk_inc >= (TICK_W+1)'(chunk_eff) && frame_inc <= {1'b0, full}) begin
          chunk_d = '0;
        end
        if (chunk_inc >= (TICK_W+1)'(chunk_eff) && frame_inc <= {1'b0, full} && !lvl) begin
          if (db_cfg_q == '0) begin
            phase_d = PH_RELEASE;
          end else begin
            phase_d = PH_CONFIRM;
            wait_d  = '0;
          end
        end else begin
          endframe_f = (frame_inc >= {1'b0, flen});
        end
      end
    endcase
    if (toggle_f) begin
      mode_d = ~mode_q;
      if (blank_cfg_q == '0) begin
        finish_f = 1'b1;
      end else begin
        phase_d = PH_BLANK;
        wait_d  = '0;
      end
    end
    if (finish_f) begin
      phase_d = PH_SHOW;
      frame_d = '0;
      chunk_d = '0;
      odd_d   = 1'b0;
    end
    if (endframe_f) begin
      frame_d = '0;
      chunk_d = '0;
      if (!mode_q) begin
        odd_d = ef_odd;
      end else begin
        pos_d  = ef_pos;
        down_d = ef_down;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      odd_q   <= 1'b0;
      pos_q   <= '0;
      down_q  <= 1'b0;
      phase_q <= PH_SHOW;
      chunk_q <= '0;
      frame_q <= '0;
      wait_q  <= '0;
    end else if (in_acc) begin
      mode_q  <= mode_d;
      odd_q   <= odd_d;
      pos_q   <= pos_d;
      down_q  <= down_d;
      phase_q <= phase_d;
      chunk_q <= chunk_d;
      frame_q <= frame_d;
      wait_q  <= wait_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) out_q <= res;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q.led_pattern;
  assign m_axis_tuser_o  = {out_q.blanking, out_q.pattern_mode};

  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !s_axis_tready_o) else $error("item accepted while remainder unit busy");

  a_cfg_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we |=> busy) else $error("register write did not restart remainder unit");

  a_blank_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && phase_q == PH_BLANK) |=> (m_axis_tdata_o == '0 && m_axis_tuser_o[1]))
    else $error("LEDs lit during blank");

  a_mode_toggle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != $past(mode_q)) |->
      ($past(in_acc) && ($past(phase_q) == PH_REL_DB || $past(phase_q) == PH_RELEASE)))
    else $error("mode changed outside release handling");

endmodule

FILE: sim/led_pattern_sequencer_top_tb.sv
`timescale 1ns / 100ps

module led_pattern_sequencer_top_tb;
  import lps_pkg::*;

  localparam int CYCLE_LIMIT = 100000;

  class led_tick_scoreboard;
    logic [CHUNK_W-1:0] chunk_reg;
    logic [DB_W-1:0]    debounce_reg;
    logic [TICK_W-1:0]  blank_reg;
    logic [TICK_W-1:0]  alt_reg;
    logic [TICK_W-1:0]  scan_reg;
    bit                 mode_q;
    bit                 odd_q;
    bit                 down_q;
    int                 pos_q;
    logic [2:0]         phase_q;
    int                 chunk_cnt;
    int                 frame_cnt;
    int                 wait_cnt;
    result_t            pending[$];
    int                 errors;

    function new();
      chunk_reg    = RST_CHECK_CHUNK;
      debounce_reg = RST_DEBOUNCE;
      blank_reg    = RST_BLANK;
      alt_reg      = RST_ALT_FRAME;
      scan_reg     = RST_SCAN_FRAME;
      mode_q       = 1'b0;
      odd_q        = 1'b0;
      down_q       = 1'b0;
      pos_q        = 0;
      phase_q      = PH_SHOW;
      chunk_cnt    = 0;
      frame_cnt    = 0;
      wait_cnt     = 0;
      errors       = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_CHECK_CHUNK: chunk_reg    = val[CHUNK_W-1:0];
        REG_DEBOUNCE:    debounce_reg = val[DB_W-1:0];
        REG_BLANK:       blank_reg    = val[TICK_W-1:0];
        REG_ALT_FRAME:   alt_reg      = val[TICK_W-1:0];
        REG_SCAN_FRAME:  scan_reg     = val[TICK_W-1:0];
        default: ;
      endcase
    endfunction

    function int frame_ticks();
      int f;
      f = mode_q ? int'(scan_reg) : int'(alt_reg);
      return (f == 0) ? 1 : f;
    endfunction

    function logic [LED_OUT_W-1:0] frame_leds();
      logic [63:0] p;
      p = '0;
      if (mode_q) begin
        if (pos_q < 64) p[pos_q] = 1'b1;
      end else begin
        for (int i = 0; i < LED_COUNT && i < 64; i++)
          if ((i & 1) == int'(odd_q)) p[i] = 1'b1;
      end
      return p[LED_OUT_W-1:0];
    endfunction

    function void next_frame();
      frame_cnt = 0;
      chunk_cnt = 0;
      if (!mode_q) begin
        odd_q = ~odd_q;
        return;
      end
      if (down_q) begin
        if (pos_q > 0) pos_q--;
      end else if (pos_q + 1 < LED_COUNT) begin
        pos_q++;
      end
      if (pos_q + 1 >= LED_COUNT) down_q = 1'b1;
      if (pos_q == 0) down_q = 1'b0;
    endfunction

    function void end_blank();
      phase_q   = PH_SHOW;
      frame_cnt = 0;
      chunk_cnt = 0;
      odd_q     = 1'b0;
    endfunction

    function void toggle_mode();
      mode_q = ~mode_q;
      if (blank_reg == 0) begin
        end_blank();
      end else begin
        phase_q  = PH_BLANK;
        wait_cnt = 0;
      end
    endfunction

    function void confirm_press(bit lvl);
      if (!lvl) begin
        phase_q = PH_RELEASE;
      end else begin
        phase_q = PH_SHOW;
        if (frame_cnt >= frame_ticks()) next_frame();
      end
    endfunction

    function void note_tick(bit lvl);
      result_t    exp;
      logic [2:0] ph;
      int         chunk;
      int         flen;
      int         full;
      bit         pressed;
      ph = (phase_q > PH_BLANK) ? PH_SHOW : phase_q;
      exp.led_pattern  = (ph == PH_BLANK) ? '0 : frame_leds();
      exp.pattern_mode = mode_q;
      exp.blanking     = (ph != PH_SHOW);
      pending.push_back(exp);
      case (ph)
        PH_CONFIRM: begin
          wait_cnt++;
          if (wait_cnt >= debounce_reg) confirm_press(lvl);
        end
        PH_RELEASE: begin
          if (lvl) begin
            if (debounce_reg == 0) begin
              toggle_mode();
            end else begin
              phase_q  = PH_REL_DB;
              wait_cnt = 0;
            end
          end
        end
        PH_REL_DB: begin
          wait_cnt++;
          if (wait_cnt >= debounce_reg) toggle_mode();
        end
        PH_BLANK: begin
          wait_cnt++;
          if (wait_cnt >= blank_reg) end_blank();
        end
        default: begin
          phase_q = PH_SHOW;
          chunk   = (chunk_reg == 0) ? 1 : int'(chunk_reg);
          flen    = frame_ticks();
          full    = (flen / chunk) * chunk;
          pressed = 1'b0;
          chunk_cnt++;
          frame_cnt++;
          if (chunk_cnt >= chunk && frame_cnt <= full) begin
            chunk_cnt = 0;
            if (!lvl) begin
              pressed = 1'b1;
              if (debounce_reg == 0) begin
                confirm_press(lvl);
              end else begin
                phase_q  = PH_CONFIRM;
                wait_cnt = 0;
              end
            end
          end
          if (!pressed && frame_cnt >= flen) next_frame();
        end
      endcase
    endfunction

    function void check_result(logic [LED_OUT_W-1:0] leds, logic mode, logic blank);
      result_t exp;
      result_t act;
      act = '{blanking: blank, pattern_mode: mode, led_pattern: leds};
      if (pending.size() == 0) begin
        $display("%0t: unexpected item leds=%h mode=%b blank=%b", $time, leds, mode, blank);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (exp !== act) begin
        $display("%0t: mismatch expected leds=%h mode=%b blank=%b, got leds=%h mode=%b blank=%b",
                 $time, exp.led_pattern, exp.pattern_mode, exp.blanking,
                 act.led_pattern, act.pattern_mode, act.blanking);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_tvalid;
  logic [7:0]            s_tdata;
  logic                  m_tready;
  logic                  cfg_valid;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  wire                   s_axis_tready;
  wire                   m_axis_tvalid;
  wire  [7:0]            m_axis_tdata;
  wire  [1:0]            m_axis_tuser;
  wire                   cfg_ready;

  int                    idle_mode = 0;
  int                    cycle_cnt = 0;
  led_tick_scoreboard    sb = new();

  led_pattern_sequencer_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    m_tready = !((idle_mode == 2 && $urandom_range(99) < 62) ||
                 (idle_mode == 3 && $urandom_range(99) < 17));
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_tready)
      sb.check_result(m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1]);
  end

  function automatic bit sender_gap();
    return (idle_mode == 1 && $urandom_range(99) < 62) ||
           (idle_mode == 3 && $urandom_range(99) < 17);
  endfunction

  // called and returns at a falling edge
  task automatic send_tick(input bit lvl);
    while (sender_gap()) begin
      s_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_tvalid = 1'b1;
    s_tdata  = {7'b0, lvl};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_tick(lvl);
    @(negedge clk_i);
    s_tvalid = 1'b0;
  endtask

  task automatic send_levels(input logic [15:0] lvls, input int n);
    for (int i = 0; i < n; i++) send_tick(lvls[i]);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val[CFG_DATA_W-1:0];
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    sb.write_reg(idx, val[CFG_DATA_W-1:0]);
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  task automatic set_timing(input int chunk, input int db, input int blank,
                            input int alt, input int scan);
    while (sb.pending.size() != 0) @(negedge clk_i);
    write_cfg(REG_CHECK_CHUNK, chunk);
    write_cfg(REG_DEBOUNCE, db);
    write_cfg(REG_BLANK, blank);
    write_cfg(REG_ALT_FRAME, alt);
    write_cfg(REG_SCAN_FRAME, scan);
  endtask

  // button held in runs, with short glitches mixed in
  task automatic press_runs(input int n, input int max_run);
    bit lvl = 1'b0;
    int run_left = 0;
    repeat (n) begin
      if (run_left == 0) begin
        lvl      = ~lvl;
        run_left = ($urandom_range(4) == 0) ? 1 : $urandom_range(max_run, 1);
      end
      send_tick(lvl);
      run_left--;
    end
  endtask

  initial begin
    int chunk;
    int db;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    m_tready  = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    rst_ni    = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    send_levels(16'b101, 3);
    // zero waits: press, release and toggle in consecutive ticks
    set_timing(1, 0, 0, 1, 1);
    send_levels(16'b11001101, 8);
    // zero chunk and frame act as one tick
    set_timing(0, 2, 3, 0, 0);
    send_levels(16'b1111111000, 10);
    // chunk longer than frame: no sample
    set_timing(5, 1, 1, 3, 3);
    send_levels(16'b0000, 4);
    // bounce on confirm: frame ends at once
    set_timing(1, 1, 1, 1, 1);
    send_levels(16'b10, 2);

    for (int p = 0; p < 10; p++) begin
      idle_mode = p % 4;
      case (p)
        0: begin
          set_timing(RST_CHECK_CHUNK, RST_DEBOUNCE, RST_BLANK, RST_ALT_FRAME, RST_SCAN_FRAME);
          press_runs(150, 80);
        end
        1: begin
          set_timing(1023, 1023, 4095, 4095, 4095);
          press_runs(40, 30);
        end
        2: begin
          set_timing(1, 0, 0, 1, 1);
          press_runs(80, 4);
        end
        default: begin
          chunk = $urandom_range(6, 1);
          db    = $urandom_range(6);
          set_timing(chunk, db, $urandom_range(8), $urandom_range(16, 1),
                     $urandom_range(16, 1));
          press_runs(70, 2 * db + chunk + 4);
        end
      endcase
    end

    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: led_pattern_sequencer_top.f
rtl/core/lps_pkg.sv
rtl/core/led_pattern_sequencer_top.sv
sim/led_pattern_sequencer_top_tb.sv
